/* rtl/core/ftpp_pkg.sv */
// Shared types and codes for the file transfer packet parser.
package ftpp_pkg;

  localparam int SIZE_BYTES_DEF = 8;
  localparam int FSIZE_W        = 63;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);

  // result kinds
  localparam logic [1:0] RK_PAYLOAD = 2'd0;
  localparam logic [1:0] RK_NAME    = 2'd1;
  localparam logic [1:0] RK_SUMMARY = 2'd2;

  // packet kinds reported in the summary
  localparam logic [1:0] PK_DATA    = 2'd0;
  localparam logic [1:0] PK_START   = 2'd1;
  localparam logic [1:0] PK_END     = 2'd2;
  localparam logic [1:0] PK_UNKNOWN = 2'd3;

  // parse status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADTYPE = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  // packet type byte codes
  localparam logic [7:0] TYPE_DATA  = 8'd1;
  localparam logic [7:0] TYPE_START = 8'd2;
  localparam logic [7:0] TYPE_END   = 8'd3;

  // TLV field types
  localparam logic [7:0] FT_SIZE = 8'd0;
  localparam logic [7:0] FT_NAME = 8'd1;

  // one classified input beat: an optional byte result and an optional summary
  typedef struct packed {
    logic               byte_vld;
    logic               byte_name;
    logic [7:0]         value;
    logic               sum_vld;
    logic [1:0]         pkind;
    logic [7:0]         seq;
    logic [15:0]        len;
    logic [FSIZE_W-1:0] fsize;
    logic [1:0]         status;
  } ftpp_ev_t;

endpackage

/* rtl/core/file_transfer_packet_parser_core.sv */
// Top level of the file transfer packet parser.
// Input: one packet byte per beat on in_rx_byte, with in_packet_end marking the
// last byte; a beat is taken when push is high and full is low.
// Output: a queue of results; while empty is low the oldest result is on the
// out_ ports and pop takes it. Each input byte gives zero, one or two results:
// a payload or filename byte (out_kind 0 or 1), and on the last byte of a packet
// a summary (out_kind 2) with type, sequence, length, file size and status.
// out_final_res marks the last result caused by one input byte.
// Throughput: one input byte per cycle while results are drained; a byte that
// ends a packet and also yields a data byte gives two results, each taken by its own pop.
// A result reaches the out_ ports through the queue and the output register: its
// event enters the queue when the byte is taken and moves into the output
// register once that register is free or its current result is popped.
// The four-entry event queue decouples the parser from the result side: when
// pop stays low the queue fills and full rises; while the queue is full the
// parser stalls every byte, even one that makes no result.
// Reset (rst_n low, synchronous) empties the queue and output register and
// puts the parser back to waiting for a packet type byte.
module file_transfer_packet_parser_core import ftpp_pkg::*; #(
  parameter int SIZE_BYTES = SIZE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_packet_end,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_value,
  output logic [1:0]         out_packet_kind,
  output logic [7:0]         out_sequence_res,
  output logic [15:0]        out_payload_length,
  output logic [FSIZE_W-1:0] out_size_of_file,
  output logic [1:0]         out_parse_status,
  output logic               out_final_res
);

  ftpp_ev_t ev, q_dout;
  logic     acc, ev_push, q_full, q_vld, q_pop;

  assign full = q_full;
  assign acc  = push && !q_full;

  ftpp_front #(.SIZE_BYTES(SIZE_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .rx_byte    (in_rx_byte),
    .packet_end (in_packet_end),
    .ev         (ev),
    .ev_push    (ev_push)
  );

  ftpp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .din   (ev),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .vld   (q_vld)
  );

  ftpp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_dout             (q_dout),
    .q_vld              (q_vld),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_packet_kind    (out_packet_kind),
    .out_sequence_res   (out_sequence_res),
    .out_payload_length (out_payload_length),
    .out_size_of_file   (out_size_of_file),
    .out_parse_status   (out_parse_status),
    .out_final_res      (out_final_res)
  );

endmodule

/* rtl/core/ftpp_front.sv */
// Front end: byte-level parser state machine that classifies each input beat.
module ftpp_front import ftpp_pkg::*; #(
  parameter int SIZE_BYTES = SIZE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  input  logic       packet_end,
  output ftpp_ev_t   ev,
  output logic       ev_push
);

  localparam int SIZE_W = 8 * SIZE_BYTES;

  typedef enum logic [3:0] {
    PH_TYPE, PH_SEQ, PH_LHI, PH_LLO, PH_PAY, PH_FTYPE, PH_FLEN, PH_FVAL, PH_SKIP
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [15:0]         cnt_r, cnt_nxt;
  logic [7:0]          seq_r, seq_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [7:0]          ftype_r, ftype_nxt;
  logic [7:0]          fleft_r, fleft_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                byte_vld, byte_name;
  logic [1:0]          sum_status;
  logic [63:0]         size64;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    cnt_nxt    = cnt_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    ftype_nxt  = ftype_r;
    fleft_nxt  = fleft_r;
    size_nxt   = size_r;
    status_nxt = status_r;
    byte_vld   = 1'b0;
    byte_name  = 1'b0;
    case (phase_r)
      PH_TYPE: begin
        seq_nxt    = '0;
        len_nxt    = '0;
        size_nxt   = '0;
        status_nxt = ST_OK;
        cnt_nxt    = '0;
        ftype_nxt  = '0;
        fleft_nxt  = '0;
        if (rx_byte == TYPE_DATA) begin
          kind_nxt  = PK_DATA;
          phase_nxt = PH_SEQ;
        end else if (rx_byte == TYPE_START) begin
          kind_nxt  = PK_START;
          phase_nxt = PH_FTYPE;
        end else if (rx_byte == TYPE_END) begin
          kind_nxt  = PK_END;
          phase_nxt = PH_FTYPE;
        end else begin
          kind_nxt   = PK_UNKNOWN;
          status_nxt = ST_BADTYPE;
          phase_nxt  = PH_SKIP;
        end
      end
      PH_SEQ: begin
        seq_nxt   = rx_byte;
        phase_nxt = PH_LHI;
      end
      PH_LHI: begin
        len_nxt   = {rx_byte, 8'd0};
        phase_nxt = PH_LLO;
      end
      PH_LLO: begin
        len_nxt   = {len_r[15:8], rx_byte};
        cnt_nxt   = '0;
        phase_nxt = (len_nxt == 16'd0) ? PH_SKIP : PH_PAY;
      end
      PH_PAY: begin
        byte_vld = 1'b1;
        cnt_nxt  = cnt_r + 16'd1;
        if (cnt_nxt >= len_r) phase_nxt = PH_SKIP;
      end
      PH_FTYPE: begin
        ftype_nxt = rx_byte;
        phase_nxt = PH_FLEN;
      end
      PH_FLEN: begin
        fleft_nxt = rx_byte;
        cnt_nxt   = '0;
        if (ftype_r == FT_SIZE) size_nxt = '0;
        phase_nxt = (rx_byte == 8'd0) ? PH_FTYPE : PH_FVAL;
      end
      PH_FVAL: begin
        if (ftype_r == FT_SIZE) begin
          // little-endian: byte lane chosen by the field byte count
          for (int i = 0; i < SIZE_BYTES; i++) begin
            if (cnt_r == 16'(i)) size_nxt[8*i +: 8] = size_r[8*i +: 8] | rx_byte;
          end
        end else if (ftype_r == FT_NAME) begin
          byte_vld  = 1'b1;
          byte_name = 1'b1;
        end
        cnt_nxt   = cnt_r + 16'd1;
        fleft_nxt = fleft_r - 8'd1;
        if (fleft_nxt == 8'd0) phase_nxt = PH_FTYPE;
      end
      default: phase_nxt = PH_SKIP;
    endcase

    // a packet that ends mid-header or mid-field gets flagged
    sum_status = status_nxt;
    if (status_nxt == ST_OK) begin
      if (phase_nxt inside {PH_SEQ, PH_LHI, PH_LLO, PH_PAY}) sum_status = ST_SHORT;
      else if (phase_nxt inside {PH_FLEN, PH_FVAL})         sum_status = ST_OVERRUN;
    end
  end

  assign size64 = 64'(size_nxt);

  always_comb begin
    ev           = '0;
    ev.byte_vld  = byte_vld;
    ev.byte_name = byte_name;
    ev.value     = rx_byte;
    ev.sum_vld   = packet_end;
    ev.pkind     = kind_nxt;
    if (kind_nxt == PK_DATA) begin
      ev.seq = seq_nxt;
      ev.len = len_nxt;
    end
    if (kind_nxt == PK_START || kind_nxt == PK_END) ev.fsize = size64[FSIZE_W-1:0];
    ev.status = sum_status;
  end

  assign ev_push = acc && (byte_vld || packet_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      kind_r   <= '0;
      cnt_r    <= '0;
      seq_r    <= '0;
      len_r    <= '0;
      ftype_r  <= '0;
      fleft_r  <= '0;
      size_r   <= '0;
      status_r <= ST_OK;
    end else if (acc) begin
      phase_r  <= packet_end ? PH_TYPE : phase_nxt;
      kind_r   <= kind_nxt;
      cnt_r    <= cnt_nxt;
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      ftype_r  <= ftype_nxt;
      fleft_r  <= fleft_nxt;
      size_r   <= size_nxt;
      status_r <= status_nxt;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && packet_end |=> phase_r == PH_TYPE)
    else $error("parser did not return to type byte after packet end");

  a_payload_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> cnt_r < len_r)
    else $error("payload count reached declared length while in payload");

  a_bad_type_skips: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !packet_end && phase_r == PH_TYPE && kind_nxt == PK_UNKNOWN
    |=> phase_r == PH_SKIP && status_r == ST_BADTYPE)
    else $error("unknown type byte not skipped");

endmodule

/* rtl/core/ftpp_queue.sv */
// Short event queue between the parser front end and the result back end.
module ftpp_queue import ftpp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ftpp_ev_t din,
  output logic     full,
  input  logic     pop,
  output ftpp_ev_t dout,
  output logic     vld
);

  ftpp_ev_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign vld     = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && vld;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count exceeds depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("event pushed into full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != (QPTR_W+1)'(QDEPTH) |-> (wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

/* rtl/core/ftpp_back.sv */
// Back end: turns queued events into result beats held in an output register.
module ftpp_back import ftpp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ftpp_ev_t           q_dout,
  input  logic               q_vld,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_value,
  output logic [1:0]         out_packet_kind,
  output logic [7:0]         out_sequence_res,
  output logic [15:0]        out_payload_length,
  output logic [FSIZE_W-1:0] out_size_of_file,
  output logic [1:0]         out_parse_status,
  output logic               out_final_res
);

  ftpp_ev_t cur_r;
  logic     cur_vld_r;
  logic     stage_r;     // set once the byte half of a two-beat event is taken
  logic     show_sum, take, two_beat, done_cur;

  assign show_sum = stage_r || !cur_r.byte_vld;
  assign take     = pop && cur_vld_r;
  assign two_beat = !stage_r && cur_r.byte_vld && cur_r.sum_vld;
  assign done_cur = take && !two_beat;
  assign q_pop    = (!cur_vld_r || done_cur) && q_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      stage_r   <= 1'b0;
    end else if (q_pop) begin
      cur_vld_r <= 1'b1;
      stage_r   <= 1'b0;
    end else if (done_cur) begin
      cur_vld_r <= 1'b0;
      stage_r   <= 1'b0;
    end else if (take) begin
      stage_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_dout;
  end

  assign empty = !cur_vld_r;

  always_comb begin
    out_kind           = RK_PAYLOAD;
    out_value          = '0;
    out_packet_kind    = '0;
    out_sequence_res   = '0;
    out_payload_length = '0;
    out_size_of_file   = '0;
    out_parse_status   = '0;
    out_final_res      = 1'b1;
    if (show_sum) begin
      out_kind           = RK_SUMMARY;
      out_packet_kind    = cur_r.pkind;
      out_sequence_res   = cur_r.seq;
      out_payload_length = cur_r.len;
      out_size_of_file   = cur_r.fsize;
      out_parse_status   = cur_r.status;
    end else begin
      out_kind      = cur_r.byte_name ? RK_NAME : RK_PAYLOAD;
      out_value     = cur_r.value;
      out_final_res = !cur_r.sum_vld;
    end
  end

  a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take && two_beat |=> cur_vld_r && show_sum)
    else $error("summary lost after byte result");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !cur_vld_r || done_cur)
    else $error("event loaded over a pending result");

  a_stage_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r |-> cur_vld_r && cur_r.sum_vld)
    else $error("second beat without a summary");

endmodule

/* tb/file_transfer_packet_parser_core_tb.sv */
// Self-checking testbench for the file transfer packet parser core.
module file_transfer_packet_parser_core_tb import ftpp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_BEATS   = 1500;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int MAX_PRINTED    = 40;

  typedef enum logic [3:0] {
    P_TYPE, P_SEQ, P_LEN_HI, P_LEN_LO, P_PAYLOAD, P_FTYPE, P_FLEN, P_FVALUE, P_DISCARD
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         value;
    logic [1:0]         pkind;
    logic [7:0]         seq;
    logic [15:0]        len;
    logic [FSIZE_W-1:0] fsize;
    logic [1:0]         status;
    logic               fin;
  } parse_result_t;

  typedef logic [7:0] byte_list_t [$];

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic [7:0]         in_rx_byte = '0;
  logic               in_packet_end = 1'b0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  logic [1:0]         out_kind;
  logic [7:0]         out_value;
  logic [1:0]         out_packet_kind;
  logic [7:0]         out_sequence_res;
  logic [15:0]        out_payload_length;
  logic [FSIZE_W-1:0] out_size_of_file;
  logic [1:0]         out_parse_status;
  logic               out_final_res;

  // parser state as seen by the predictor
  parse_phase_t ph = P_TYPE;
  logic [1:0]   pk_seen = '0;
  logic [15:0]  cnt = '0;
  logic [7:0]   seq_q = '0;
  logic [15:0]  len_q = '0;
  logic [7:0]   ftype_q = '0;
  logic [7:0]   fleft_q = '0;
  logic [63:0]  fsize_acc = '0;
  logic [1:0]   stat_q = '0;

  parse_result_t pending_results [$];
  int err_count = 0;
  int beats_sent = 0;
  int rx_hold_req = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;

  file_transfer_packet_parser_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_rx_byte         (in_rx_byte),
    .in_packet_end      (in_packet_end),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_packet_kind    (out_packet_kind),
    .out_sequence_res   (out_sequence_res),
    .out_payload_length (out_payload_length),
    .out_size_of_file   (out_size_of_file),
    .out_parse_status   (out_parse_status),
    .out_final_res      (out_final_res)
  );

  always #2 clk = ~clk;

  function automatic int rand_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic parse_result_t byte_result(logic [1:0] kind, logic [7:0] v, logic fin);
    parse_result_t r;
    r = '0;
    r.kind = kind;
    r.value = v;
    r.fin = fin;
    return r;
  endfunction

  // advance the parser state by one byte and queue the results it yields
  task automatic predict_beat(input logic [7:0] b, input logic last);
    parse_result_t r;
    logic [1:0] st;
    case (ph)
      P_TYPE: begin
        seq_q = '0; len_q = '0; fsize_acc = '0; stat_q = ST_OK;
        cnt = '0; ftype_q = '0; fleft_q = '0;
        if (b == TYPE_DATA) begin
          pk_seen = PK_DATA; ph = P_SEQ;
        end else if (b == TYPE_START) begin
          pk_seen = PK_START; ph = P_FTYPE;
        end else if (b == TYPE_END) begin
          pk_seen = PK_END; ph = P_FTYPE;
        end else begin
          pk_seen = PK_UNKNOWN; stat_q = ST_BADTYPE; ph = P_DISCARD;
        end
      end
      P_SEQ: begin
        seq_q = b; ph = P_LEN_HI;
      end
      P_LEN_HI: begin
        len_q = {b, 8'h00}; ph = P_LEN_LO;
      end
      P_LEN_LO: begin
        len_q[7:0] = b;
        cnt = '0;
        ph = (len_q == 16'd0) ? P_DISCARD : P_PAYLOAD;
      end
      P_PAYLOAD: begin
        pending_results.push_back(byte_result(RK_PAYLOAD, b, !last));
        cnt = cnt + 16'd1;
        if (cnt >= len_q) ph = P_DISCARD;
      end
      P_FTYPE: begin
        ftype_q = b; ph = P_FLEN;
      end
      P_FLEN: begin
        fleft_q = b;
        cnt = '0;
        if (ftype_q == FT_SIZE) fsize_acc = '0;
        ph = (b == 8'd0) ? P_FTYPE : P_FVALUE;
      end
      P_FVALUE: begin
        if (ftype_q == FT_SIZE) begin
          if (cnt < SIZE_BYTES_DEF && cnt < 16'd8) fsize_acc |= 64'(b) << (8 * cnt);
        end else if (ftype_q == FT_NAME) begin
          pending_results.push_back(byte_result(RK_NAME, b, !last));
        end
        cnt = cnt + 16'd1;
        fleft_q = fleft_q - 8'd1;
        if (fleft_q == 8'd0) ph = P_FTYPE;
      end
      default: ph = P_DISCARD;
    endcase

    if (last) begin
      st = stat_q;
      if (st == ST_OK) begin
        if (ph inside {P_SEQ, P_LEN_HI, P_LEN_LO, P_PAYLOAD}) st = ST_SHORT;
        else if (ph inside {P_FLEN, P_FVALUE}) st = ST_OVERRUN;
      end
      r = '0;
      r.kind = RK_SUMMARY;
      r.pkind = pk_seen;
      if (pk_seen == PK_DATA) begin
        r.seq = seq_q;
        r.len = len_q;
      end
      if (pk_seen == PK_START || pk_seen == PK_END) r.fsize = fsize_acc[FSIZE_W-1:0];
      r.status = st;
      r.fin = 1'b1;
      pending_results.push_back(r);
      ph = P_TYPE;
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string fname, input logic [63:0] got,
                             input logic [63:0] want_v);
    if (got !== want_v) report_mismatch($sformatf("%s got %0h expected %0h", fname, got, want_v));
  endtask

  // leaves push high when the next beat follows back to back
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    push <= 1'b1;
    in_rx_byte <= b;
    in_packet_end <= last;
    do @(posedge clk); while (full);
    predict_beat(b, last);
    beats_sent++;
    gap = rand_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet(input byte_list_t pkt);
    foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_bad_type();
    byte_list_t pkt;
    pkt = {8'hFF};
    send_packet(pkt);
    pkt = {8'h00, 8'h5A};
    send_packet(pkt);
  endtask

  task automatic test_data_packets();
    byte_list_t pkt;
    // one byte past the declared length is dropped
    pkt = {TYPE_DATA, 8'hFF, 8'h00, 8'h01, 8'hAA, 8'h55};
    send_packet(pkt);
    // declared 0xffff, only one payload byte arrives
    pkt = {TYPE_DATA, 8'h00, 8'hFF, 8'hFF, 8'h80};
    send_packet(pkt);
    // header cut off after the type byte
    pkt = {TYPE_DATA};
    send_packet(pkt);
  endtask

  task automatic test_control_packets();
    byte_list_t pkt;
    // two-byte size field, then a name whose byte ends the packet
    pkt = {TYPE_START, FT_SIZE, 8'h02, 8'h34, 8'h12, FT_NAME, 8'h01, 8'h41};
    send_packet(pkt);
    pkt = {TYPE_END};
    send_packet(pkt);
    // packet ends inside a field value
    pkt = {TYPE_END, FT_SIZE, 8'h04, 8'h11};
    send_packet(pkt);
  endtask

  // receiver stops popping while a long payload keeps coming
  task automatic test_receiver_holdoff();
    byte_list_t pkt;
    pkt = {TYPE_DATA, 8'h3C, 8'h00, 8'd40};
    repeat (40) pkt.push_back(8'($urandom));
    rx_hold_req = HOLDOFF_CYCLES;
    idle_en = 1'b0;
    send_packet(pkt);
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    byte_list_t pkt;
    int start, r, n, mode, cut, flen;
    logic [15:0] dlen;
    logic [7:0] ftype;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      if ($urandom_range(0, 19) == 0) idle_en = !idle_en;
      pkt.delete();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        dlen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        pkt = {TYPE_DATA, 8'($urandom), dlen[15:8], dlen[7:0]};
        mode = $urandom_range(0, 9);
        if (dlen > 16'd12) n = $urandom_range(0, 6);
        else if (mode == 0) n = int'(dlen) + $urandom_range(1, 3);
        else if (mode == 1 && dlen > 16'd0) n = $urandom_range(0, int'(dlen) - 1);
        else n = int'(dlen);
        repeat (n) pkt.push_back(8'($urandom));
        if ($urandom_range(0, 19) == 0) begin
          cut = $urandom_range(1, 3);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end
      end else if (r < 85) begin
        pkt.push_back($urandom_range(0, 1) ? TYPE_START : TYPE_END);
        repeat ($urandom_range(0, 3)) begin
          mode = $urandom_range(0, 9);
          if (mode < 4) begin
            ftype = FT_SIZE;
            flen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 8;
          end else if (mode < 8) begin
            ftype = FT_NAME;
            flen = $urandom_range(0, 6);
          end else begin
            ftype = 8'($urandom_range(2, 255));
            flen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
          end
          pkt.push_back(ftype);
          pkt.push_back(8'(flen));
          repeat (flen) pkt.push_back(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0 && pkt.size() > 1) begin
          cut = $urandom_range(1, pkt.size() - 1);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end
      end else begin
        pkt.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
      end
      send_packet(pkt);
    end
    idle_en = 1'b1;
  endtask

  // result side: random pop gaps plus a requested long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        stall_left = rand_gap();
        pop <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing expected", out_kind));
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", out_kind, want.kind);
        check_field("out_value", out_value, want.value);
        check_field("out_packet_kind", out_packet_kind, want.pkind);
        check_field("out_sequence_res", out_sequence_res, want.seq);
        check_field("out_payload_length", out_payload_length, want.len);
        check_field("out_size_of_file", out_size_of_file, want.fsize);
        check_field("out_parse_status", out_parse_status, want.status);
        check_field("out_final_res", out_final_res, want.fin);
      end
    end
  end

  // cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_bad_type();
    test_data_packets();
    test_control_packets();
    wait_drained();
    test_receiver_holdoff();
    test_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* file_transfer_packet_parser_core.f */
rtl/core/ftpp_pkg.sv
rtl/core/ftpp_front.sv
rtl/core/ftpp_queue.sv
rtl/core/ftpp_back.sv
rtl/core/file_transfer_packet_parser_core.sv
tb/file_transfer_packet_parser_core_tb.sv
